FILE: hdl/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// Shared widths and the request/response structs of the shared multiplier.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int WORD_W = 32;
  localparam int PROD_W = 64;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] a;
    logic [PROD_W-1:0] b;
  } pes_mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] result;
  } pes_mul_rsp_t;

endpackage

FILE: hdl/pes_if.sv
// ----------------------------------------------------------------------------
// pes_if
// Valid/ready channels for input elements and for result words.
// ----------------------------------------------------------------------------
interface pes_in_if;
  import pes_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value;
  logic              last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface pes_out_if;
  import pes_pkg::*;

  logic              valid;
  logic              ready;
  logic [PROD_W-1:0] product;
  logic              last_out;

  modport source (output valid, output product, output last_out, input ready);
  modport sink (input valid, input product, input last_out, output ready);
endinterface

FILE: hdl/pes_mul.sv
// ----------------------------------------------------------------------------
// pes_mul
// Shared 64 x 64 -> 64 (mod 2^64) multiplier built from one 32 x 32 unit,
// three partial products formed in turn.
// ----------------------------------------------------------------------------
module pes_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  pes_pkg::pes_mul_req_t req,
  output pes_pkg::pes_mul_rsp_t rsp
);
  import pes_pkg::*;

  logic [PROD_W-1:0] a;
  logic [PROD_W-1:0] b;
  logic [PROD_W-1:0] pp;
  logic [PROD_W-1:0] acc;
  logic [1:0]        step;
  logic              busy;
  logic [WORD_W-1:0] opa;
  logic [WORD_W-1:0] opb;

  // lo*lo, then the two cross terms; only their low halves reach the result
  always_comb begin
    case (step)
      2'd0: begin
        opa = a[WORD_W-1:0];
        opb = b[WORD_W-1:0];
      end
      2'd1: begin
        opa = a[PROD_W-1:WORD_W];
        opb = b[WORD_W-1:0];
      end
      2'd2: begin
        opa = a[WORD_W-1:0];
        opb = b[PROD_W-1:WORD_W];
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= 2'd0;
    end else if (busy) begin
      step <= step + 2'd1;
      if (step == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
    end
    pp <= PROD_W'(opa) * PROD_W'(opb);
    if (step == 2'd1) begin
      acc <= pp;
    end else if (step == 2'd2) begin
      acc[PROD_W-1:WORD_W] <= acc[PROD_W-1:WORD_W] + pp[WORD_W-1:0];
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = busy && (step == 2'd3);
  assign rsp.result = {acc[PROD_W-1:WORD_W] + pp[WORD_W-1:0], acc[WORD_W-1:0]};

endmodule

FILE: hdl/product_except_self_top.sv
// Non-final element: one pass of the shared multiplier forms the next prefix
// product before the block is ready for another element.
// Final element: backward sweep of two multiplier passes plus one memory read
// per element, then one word at a time through S_EM_RD and S_EM_LD, each
// waiting for a free output register; the last word may wait there while the
// next vector loads. Synchronous active-high reset empties the vector buffer.
// ----------------------------------------------------------------------------
// product_except_self_top
// Product of all other vector elements, mod 2^64, from prefix products and
// elements in two memories, a suffix register, one shared iterative multiplier.
// ----------------------------------------------------------------------------
module product_except_self_top #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  pes_in_if.sink    data,
  pes_out_if.source result
);
  import pes_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_LD_MUL = 3'd1;
  localparam logic [2:0] S_SW_RD  = 3'd2;
  localparam logic [2:0] S_SW_M1  = 3'd3;
  localparam logic [2:0] S_SW_W1  = 3'd4;
  localparam logic [2:0] S_SW_W2  = 3'd5;
  localparam logic [2:0] S_EM_RD  = 3'd6;
  localparam logic [2:0] S_EM_LD  = 3'd7;

  logic [2:0]        state;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     k;
  logic [AW-1:0]     last_idx;
  logic [PROD_W-1:0] run_prefix;
  logic [PROD_W-1:0] suffix;
  logic              out_valid;
  logic [PROD_W-1:0] out_product;
  logic              out_last;

  logic [WORD_W-1:0] value_mem [DEPTH];
  logic [PROD_W-1:0] prefix_mem [DEPTH];
  logic [WORD_W-1:0] v_rd;
  logic [PROD_W-1:0] p_rd;

  logic              accept;
  logic              final_item;
  logic              val_we;
  logic              pre_we;
  logic [AW-1:0]     wr_addr;
  logic [PROD_W-1:0] pre_wdata;

  pes_mul_req_t mul_req;
  pes_mul_rsp_t mul_rsp;

  pes_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign idx        = cnt[AW-1:0];
  assign accept     = data.valid && data.ready;
  assign final_item = data.last || (cnt == CW'(DEPTH - 1));

  assign data.ready      = (state == S_LOAD);
  assign result.valid    = out_valid;
  assign result.product  = out_product;
  assign result.last_out = out_last;

  assign val_we    = (state == S_LOAD) && accept;
  assign pre_we    = val_we || ((state == S_SW_W1) && mul_rsp.done);
  assign wr_addr   = (state == S_LOAD) ? idx : k;
  assign pre_wdata = (state == S_LOAD) ? run_prefix : mul_rsp.result;

  always_comb begin
    mul_req = '0;
    case (state)
      S_LOAD: begin
        if (accept && !final_item) begin
          mul_req.start = 1'b1;
          mul_req.a     = run_prefix;
          mul_req.b     = PROD_W'(data.value);
        end
      end
      S_SW_M1: begin
        mul_req.start = 1'b1;
        mul_req.a     = p_rd;
        mul_req.b     = suffix;
      end
      S_SW_W1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = suffix;
          mul_req.b     = PROD_W'(v_rd);
        end
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // one write port and one read port per store, read address always the sweep/emit index
  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[wr_addr] <= data.value;
    end
    v_rd <= value_mem[k];
  end

  always_ff @(posedge clk) begin
    if (pre_we) begin
      prefix_mem[wr_addr] <= pre_wdata;
    end
    p_rd <= prefix_mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      cnt        <= '0;
      k          <= '0;
      last_idx   <= '0;
      run_prefix <= PROD_W'(1);
      suffix     <= PROD_W'(1);
      out_valid  <= 1'b0;
    end else begin
      if (state == S_EM_LD) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (final_item) begin
              cnt        <= '0;
              run_prefix <= PROD_W'(1);
              suffix     <= PROD_W'(1);
              k          <= idx;
              last_idx   <= idx;
              state      <= S_SW_RD;
            end else begin
              cnt   <= cnt + CW'(1);
              state <= S_LD_MUL;
            end
          end
        end
        S_LD_MUL: begin
          if (mul_rsp.done) begin
            run_prefix <= mul_rsp.result;
            state      <= S_LOAD;
          end
        end
        S_SW_RD: begin
          state <= S_SW_M1;
        end
        S_SW_M1: begin
          state <= S_SW_W1;
        end
        S_SW_W1: begin
          if (mul_rsp.done) begin
            state <= S_SW_W2;
          end
        end
        S_SW_W2: begin
          if (mul_rsp.done) begin
            suffix <= mul_rsp.result;
            if (k == '0) begin
              state <= S_EM_RD;
            end else begin
              k     <= k - AW'(1);
              state <= S_SW_RD;
            end
          end
        end
        S_EM_RD: begin
          // wait until the output register is free for the next word
          if (!out_valid || result.ready) begin
            state <= S_EM_LD;
          end
        end
        S_EM_LD: begin
          if (k == last_idx) begin
            k     <= '0;
            state <= S_LOAD;
          end else begin
            k     <= k + AW'(1);
            state <= S_EM_RD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EM_LD) begin
      out_product <= p_rd;
      out_last    <= (k == last_idx);
    end
  end

`ifndef SYNTHESIS
  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> (!mul_rsp.busy || mul_rsp.done))
    else $error("multiplier started while busy");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EM_LD) |-> !out_valid)
    else $error("result word loaded over a pending word");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    accept |-> (cnt <= CW'(DEPTH - 1)))
    else $error("element count beyond buffer depth");
`endif

endmodule

FILE: tb/sv/product_except_self_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// product_except_self_top_tb
// Sends vectors of elements to the block and checks every result word against
// a predictor that forms prefix and suffix products, or for typed rows against
// the table. The run begins with a stimulus table of corner cases, then
// continues with random vectors that include full-depth vectors with and
// without a last flag. Both sides stall at random.
// ----------------------------------------------------------------------------
module product_except_self_top_tb;
  import pes_pkg::*;

  localparam int VEC_MAX      = 64;
  localparam int STALL_MAX    = 9;
  localparam int RANDOM_ITEMS = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 50;
  localparam int N_DIRECTED   = 25;

  typedef struct packed {
    logic [PROD_W-1:0] product;
    logic              last_out;
  } result_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              last;
    logic              typed;
    logic [PROD_W-1:0] product;
  } stim_row_t;

  // typed rows are one-element vectors, whose only result is 1
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 64'd1},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 64'd1},
    '{32'h0000_0001, 1'b1, 1'b1, 64'd1},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 64'd0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 64'd0},
    '{32'h0000_0005, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0000, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0007, 1'b1, 1'b0, 64'd0},
    '{32'h0000_0000, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0003, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0000, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0009, 1'b1, 1'b0, 64'd0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 64'd0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 64'd0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 64'd0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 64'd0},
    '{32'h8000_0000, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0002, 1'b0, 1'b0, 64'd0},
    '{32'h8000_0000, 1'b1, 1'b0, 64'd0},
    '{32'h0000_0001, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0001, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0002, 1'b0, 1'b0, 64'd0},
    '{32'h0000_0003, 1'b0, 1'b0, 64'd0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 64'd0},
    '{32'h5555_5555, 1'b1, 1'b0, 64'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  pes_in_if  data_if ();
  pes_out_if result_if ();

  product_except_self_top #(
    .DEPTH(VEC_MAX)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .data(data_if),
    .result(result_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [WORD_W-1:0] held_value [VEC_MAX];
  int                held_cnt = 0;
  result_word_t      fresh_words [$];
  result_word_t      awaited_words [$];

  int mismatch_cnt    = 0;
  int words_checked   = 0;
  int vectors_done    = 0;
  int elements_sent   = 0;
  int full_vectors    = 0;
  int unflagged_fulls = 0;
  bit tx_steady       = 1'b0;
  bit rx_steady       = 1'b0;
  int idle_cycles     = 0;

  // takes one element; once the vector closes, fills fresh_words with the
  // product of all other elements for each position
  function automatic int absorb_element(logic [WORD_W-1:0] v, logic is_last);
    logic [PROD_W-1:0] lead_prod [VEC_MAX];
    logic [PROD_W-1:0] running;
    logic [PROD_W-1:0] trail;
    int                n;
    fresh_words.delete();
    held_value[held_cnt] = v;
    held_cnt++;
    if (!is_last && held_cnt < VEC_MAX) return 0;
    n = held_cnt;
    running = 64'd1;
    for (int i = 0; i < n; i++) begin
      lead_prod[i] = running;
      running = running * held_value[i];
    end
    trail = 64'd1;
    for (int i = n - 1; i >= 0; i--) begin
      lead_prod[i] = lead_prod[i] * trail;
      trail = trail * held_value[i];
    end
    for (int i = 0; i < n; i++)
      fresh_words.push_back(result_word_t'{lead_prod[i], i == n - 1});
    held_cnt = 0;
    return n;
  endfunction

  function automatic logic [WORD_W-1:0] draw_value();
    case ($urandom_range(0, 15))
      0:          return '0;
      1:          return 32'd1;
      2:          return '1;
      3, 4:       return 32'd1 << $urandom_range(0, 31);
      5, 6, 7, 8: return $urandom_range(2, 1000);
      default:    return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic check_word(result_word_t got);
    result_word_t want;
    if (awaited_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word product=%h last_out=%b",
                                got.product, got.last_out));
      return;
    end
    want = awaited_words.pop_front();
    words_checked++;
    if (got.product !== want.product)
      report_mismatch($sformatf("product %h, wanted %h", got.product, want.product));
    if (got.last_out !== want.last_out)
      report_mismatch($sformatf("last_out %b, wanted %b", got.last_out, want.last_out));
  endtask

  task automatic send_element(logic [WORD_W-1:0] v, logic is_last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      data_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_if.valid <= 1'b1;
    data_if.value <= v;
    data_if.last  <= is_last;
    do @(posedge clk); while (!data_if.ready);
    elements_sent++;
  endtask

  task automatic issue_element(logic [WORD_W-1:0] v, logic is_last, logic typed,
                               logic [PROD_W-1:0] typed_product);
    int n;
    send_element(v, is_last);
    n = absorb_element(v, is_last);
    if (n > 0) begin
      vectors_done++;
      if (n == VEC_MAX) begin
        full_vectors++;
        if (!is_last) unflagged_fulls++;
      end
      if (typed) awaited_words.push_back(result_word_t'{typed_product, 1'b1});
      else foreach (fresh_words[i]) awaited_words.push_back(fresh_words[i]);
    end
  endtask

  task automatic hold_until_drained();
    data_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int len;
    int rand_items;
    int vec_idx;
    bit flag_full;
    data_if.valid = 1'b0;
    data_if.value = '0;
    data_if.last  = 1'b0;
    rand_items = 0;
    vec_idx = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      issue_element(directed_rows[r].value, directed_rows[r].last,
                    directed_rows[r].typed, directed_rows[r].product);
    hold_until_drained();

    while (rand_items < RANDOM_ITEMS) begin
      if (vec_idx == 5 || vec_idx == 20 || $urandom_range(0, 39) == 0) len = VEC_MAX;
      else if ($urandom_range(0, 5) == 0) len = $urandom_range(9, 20);
      else len = $urandom_range(1, 8);
      // a full-depth vector closes itself whether or not the last flag is set
      flag_full = (vec_idx == 5) ? 1'b0 : (vec_idx == 20) ? 1'b1 : 1'($urandom_range(0, 1));
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < len; k++)
        issue_element(draw_value(), (k == len - 1) && (len < VEC_MAX || flag_full),
                      1'b0, '0);
      rand_items += len;
      vec_idx++;
      if (vec_idx % 12 == 0) hold_until_drained();
    end

    data_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d elements in %0d vectors, %0d of full depth (%0d closed without a flag)",
             elements_sent, vectors_done, full_vectors, unflagged_fulls);
    $display("checked %0d result words, %0d mismatches", words_checked, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result side
  initial begin
    int stall;
    result_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      check_word(result_word_t'{result_if.product, result_if.last_out});
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (data_if.valid && data_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, awaited_words.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
